FILE: sv/m4cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4cm_pkg
// Shared types and constants of the 4x4 column-major Q16.16 matrix multiplier.
// ----------------------------------------------------------------------------
package m4cm_pkg;

    localparam int ELEM_W = 32;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int DIM    = 4;
    localparam int COL_W  = 2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MUL  = 1'b1;

    typedef logic signed [ELEM_W-1:0] m4cm_elem_t;
    typedef logic signed [PROD_W-1:0] m4cm_prod_t;

    typedef struct packed {
        logic             req_type;
        logic [COL_W-1:0] column;
        m4cm_elem_t       elem_row0;
        m4cm_elem_t       elem_row1;
        m4cm_elem_t       elem_row2;
        m4cm_elem_t       elem_row3;
    } m4cm_req_t;

    typedef struct packed {
        logic [COL_W-1:0] result_column;
        m4cm_elem_t       res_row0;
        m4cm_elem_t       res_row1;
        m4cm_elem_t       res_row2;
        m4cm_elem_t       res_row3;
        logic             overflow;
    } m4cm_res_t;

    // valid bit and column index that travel down the pipeline
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] column;
    } m4cm_tag_t;

    // per-stage load enables handed to the reduction stages
    typedef struct packed {
        logic ready_s2;
        logic ready_s3;
    } m4cm_hold_t;

endpackage

FILE: sv/m4cm_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4cm_mult
// First pipeline stage: the sixteen 32x32 signed products of the stored left
// matrix with the incoming right column, registered.
// ----------------------------------------------------------------------------
module m4cm_mult (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ready,
    input  m4cm_pkg::m4cm_tag_t               tag_in,
    input  m4cm_pkg::m4cm_elem_t              left  [m4cm_pkg::DIM*m4cm_pkg::DIM],
    input  m4cm_pkg::m4cm_elem_t              x     [m4cm_pkg::DIM],
    output m4cm_pkg::m4cm_tag_t               tag_reg,
    output m4cm_pkg::m4cm_prod_t              prod_reg [m4cm_pkg::DIM][m4cm_pkg::DIM]
);
    import m4cm_pkg::*;

    m4cm_prod_t prod_next [DIM][DIM];

    // prod[r][k] = L[r][k] * x[k], left matrix stored column-major
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            for (int k = 0; k < DIM; k++)
            begin
                prod_next[r][k] = left[k*DIM + r] * x[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (ready)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && tag_in.valid)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

FILE: sv/m4cm_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4cm_reduce
// Second and third pipeline stages: floor the products to the fixed-point
// scale, add them in pairs, then add the pairs and saturate to 32 bits.
// ----------------------------------------------------------------------------
module m4cm_reduce #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  m4cm_pkg::m4cm_hold_t hold,
    input  m4cm_pkg::m4cm_tag_t  tag_in,
    input  m4cm_pkg::m4cm_prod_t prod [m4cm_pkg::DIM][m4cm_pkg::DIM],
    output m4cm_pkg::m4cm_tag_t  tag_s2_reg,
    output logic                 res_valid_reg,
    output m4cm_pkg::m4cm_res_t  res_reg
);
    import m4cm_pkg::*;

    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int PAIR_W = SH_W + 1;
    localparam int TOT_W  = SH_W + 2;
    localparam logic signed [TOT_W-1:0] SAT_MAX =
        {{(TOT_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
    localparam logic signed [TOT_W-1:0] SAT_MIN =
        {{(TOT_W-ELEM_W+1){1'b1}}, {(ELEM_W-1){1'b0}}};

    logic signed [SH_W-1:0]   sh        [DIM][DIM];
    logic signed [PAIR_W-1:0] pair_next [DIM][2];
    logic signed [PAIR_W-1:0] pair_reg  [DIM][2];
    logic signed [TOT_W-1:0]  tot       [DIM];
    m4cm_elem_t               sat       [DIM];
    logic [DIM-1:0]           clip;
    m4cm_res_t                res_next;

    // dropping the low bits of a signed product is a floor division
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            for (int k = 0; k < DIM; k++)
            begin
                sh[r][k] = prod[r][k][PROD_W-1:FRAC_BITS];
            end
            pair_next[r][0] = PAIR_W'(sh[r][0]) + PAIR_W'(sh[r][1]);
            pair_next[r][1] = PAIR_W'(sh[r][2]) + PAIR_W'(sh[r][3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s2_reg <= '0;
        end
        else if (hold.ready_s2)
        begin
            tag_s2_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold.ready_s2 && tag_in.valid)
        begin
            pair_reg <= pair_next;
        end
    end

    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            tot[r] = TOT_W'(pair_reg[r][0]) + TOT_W'(pair_reg[r][1]);
            if (tot[r] > SAT_MAX)
            begin
                sat[r]  = SAT_MAX[ELEM_W-1:0];
                clip[r] = 1'b1;
            end
            else if (tot[r] < SAT_MIN)
            begin
                sat[r]  = SAT_MIN[ELEM_W-1:0];
                clip[r] = 1'b1;
            end
            else
            begin
                sat[r]  = tot[r][ELEM_W-1:0];
                clip[r] = 1'b0;
            end
        end
        res_next.result_column = tag_s2_reg.column;
        res_next.res_row0      = sat[0];
        res_next.res_row1      = sat[1];
        res_next.res_row2      = sat[2];
        res_next.res_row3      = sat[3];
        res_next.overflow      = |clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (hold.ready_s3)
        begin
            res_valid_reg <= tag_s2_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold.ready_s3 && tag_s2_reg.valid)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: sv/mat4_column_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_column_multiply
// Column-major 4x4 Q16.16 matrix product against a stored left matrix.
// ----------------------------------------------------------------------------
// A load word writes one column of the left matrix at the edge it is taken and
// gives no result; a multiply word taken at the next edge already sees it. A
// multiply word's result column is presented on the output once it has been
// registered in each stage, and one word can be taken every cycle while
// req_stall is low. The three stages are the 32x32 multiplier
// bank, the pair adders, and the final adder with saturation; each stage moves
// on whenever the one after it is empty or moving, so bubbles close up and
// req_stall rises only when all three stages hold results and res_stall is set.
module mat4_column_multiply #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  m4cm_pkg::m4cm_req_t req_word,
    output logic                res_valid,
    input  logic                res_stall,
    output m4cm_pkg::m4cm_res_t res_word
);
    import m4cm_pkg::*;

    m4cm_elem_t left_reg  [DIM*DIM];
    m4cm_elem_t left_next [DIM*DIM];
    m4cm_elem_t x         [DIM];
    m4cm_prod_t prod      [DIM][DIM];
    m4cm_tag_t  tag_in;
    m4cm_tag_t  tag_s1;
    m4cm_tag_t  tag_s2;
    m4cm_hold_t hold;
    logic       ready_s1;
    logic       accept;

    assign x[0] = req_word.elem_row0;
    assign x[1] = req_word.elem_row1;
    assign x[2] = req_word.elem_row2;
    assign x[3] = req_word.elem_row3;

    assign hold.ready_s3 = !res_valid || !res_stall;
    assign hold.ready_s2 = !tag_s2.valid || hold.ready_s3;
    assign ready_s1      = !tag_s1.valid || hold.ready_s2;
    assign req_stall     = !ready_s1;
    assign accept        = req_valid && ready_s1;

    assign tag_in.valid  = accept && (req_word.req_type == REQ_MUL);
    assign tag_in.column = req_word.column;

    always_comb
    begin
        left_next = left_reg;
        if (accept && (req_word.req_type == REQ_LOAD))
        begin
            for (int r = 0; r < DIM; r++)
            begin
                left_next[{req_word.column, 2'(r)}] = x[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIM*DIM; i++)
            begin
                left_reg[i] <= '0;
            end
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    m4cm_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .ready    (ready_s1),
        .tag_in   (tag_in),
        .left     (left_reg),
        .x        (x),
        .tag_reg  (tag_s1),
        .prod_reg (prod)
    );

    m4cm_reduce #(
        .FRAC_BITS (FRAC_BITS)
    ) u_reduce (
        .clk           (clk),
        .rst_n         (rst_n),
        .hold          (hold),
        .tag_in        (tag_s1),
        .prod          (prod),
        .tag_s2_reg    (tag_s2),
        .res_valid_reg (res_valid),
        .res_reg       (res_word)
    );

endmodule

FILE: sv/m4cm_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4cm_check
// Port-level checks of the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module m4cm_check (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input m4cm_pkg::m4cm_req_t req_word,
    input logic                res_valid,
    input logic                res_stall,
    input m4cm_pkg::m4cm_res_t res_word
);
    import m4cm_pkg::*;

    localparam m4cm_elem_t EMAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam m4cm_elem_t EMIN = {1'b1, {(ELEM_W-1){1'b0}}};

    // a held result word stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    // the input side only backs up when the output side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid && res_stall)
        else $error("input stalled with output free");

    // an overflow flag needs at least one row at a saturation limit
    a_ovf_rows: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.overflow |->
            res_word.res_row0 == EMAX || res_word.res_row0 == EMIN ||
            res_word.res_row1 == EMAX || res_word.res_row1 == EMIN ||
            res_word.res_row2 == EMAX || res_word.res_row2 == EMIN ||
            res_word.res_row3 == EMAX || res_word.res_row3 == EMIN)
        else $error("overflow set with no saturated row");

    // a stalled input word stays offered and unchanged
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_word))
        else $error("input word changed while stalled");

endmodule

bind mat4_column_multiply m4cm_check u_check (.*);
